[rtl/core/glzw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the GIF LZW decoder.
// No dependencies; the decoder unit, the dictionary and the testbench use this package.
package glzw_pkg;

  localparam int BUF_BITS = 20;
  localparam int CNT_W    = 5;
  localparam int CODE_W   = 12;
  localparam int ENT_W    = 13;
  localparam int CW_W     = 4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_PULL  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADCODE = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK_DAT,
    S_FIX,
    S_POP_DAT,
    S_DONE
  } state_t;

  localparam logic [0:0] REG_PALETTE = 1'b0;
  localparam logic [0:0] REG_MINSIZE = 1'b1;

endpackage

[rtl/core/glzw_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing.
interface glzw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface glzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       pixel_valid;
  logic       need_byte;
  logic       image_end;
  logic [1:0] status;
  modport source (output valid, pixel, pixel_valid, need_byte, image_end, status,
                  input ready);
  modport sink (input valid, pixel, pixel_valid, need_byte, image_end, status,
                output ready);
endinterface

[rtl/core/gif_lzw_decoder_unit.sv]
`timescale 1ns / 1ps
// GIF LZW decoder: compressed bytes in, palette indices out, one result per beat.
// Input beat: action (push byte, pull pixel, start image, no-op) and data_byte.
// Result beat: pixel, pixel_valid, need_byte, image_end and status.
// Registers over APB: palette_bits at 0x0, min_code_size at 0x4; write only while idle.
// One item is in flight at a time; the next input beat is taken once the
// previous result is loaded into the output register, even if it is not yet taken.
// Push, start and no-op beats go from idle straight to the result state. A pull
// pops one pixel through a stack read when the stack holds pixels. A pull with an
// empty stack decodes codes first, each in a decode step; a code that goes
// through the dictionary adds a read and a data step per chain step (the dictionary
// read port is registered), then steps to push the root pixel and add the entry.
// Reset (synchronous, active low) empties the bit buffer, stack and dictionary
// count; the memories are not cleared, entries are used only once written.
// When the receiver stalls, the result is held in the output register and the
// block holds the following item before its result until the register frees up.
// Uses glzw_pkg, glzw_chan_if, glzw_dict and glzw_stack.
module gif_lzw_decoder_unit #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_CODE_BITS = 12,
  parameter int STACK_DEPTH   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  glzw_in_if.sink     in_ch,
  glzw_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int GW  = $clog2(DICT_ENTRIES + 1);
  localparam int BB  = glzw_pkg::BUF_BITS;
  localparam int EW  = glzw_pkg::ENT_W;
  localparam int CDW = glzw_pkg::CODE_W;

  glzw_pkg::state_t state_r, state_nxt;

  logic [2:0]            pb_r;
  logic [3:0]            msz_r;
  logic [BB-1:0]         buf_r, buf_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [3:0]            cw_r, cw_nxt;
  logic [EW-1:0]         ec_r, ec_nxt;
  logic [CDW-1:0]        prev_r, prev_nxt;
  logic                  aclr_r, aclr_nxt;
  logic                  stop_r, stop_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  logic [CDW-1:0]        c_r, c_nxt;
  logic [CDW-1:0]        cur_r, cur_nxt;
  logic                  kwk_r, kwk_nxt;
  logic [SAW-1:0]        base_r, base_nxt;
  logic                  rsv_r, rsv_nxt;
  logic [7:0]            f_r, f_nxt;
  logic [GW-1:0]         guard_r, guard_nxt;
  logic [1:0]            act_r;
  logic [1:0]            stat_r, stat_nxt;
  logic [7:0]            pix_r, pix_nxt;
  logic                  pv_r, pv_nxt;

  logic                  ov_r;
  logic [7:0]            o_pix_r;
  logic                  o_pv_r, o_need_r, o_end_r;
  logic [1:0]            o_stat_r;

  logic                  d_we;
  logic [DAW-1:0]        d_waddr, d_raddr;
  logic [CDW-1:0]        d_rprefix;
  logic [7:0]            d_rsuffix;
  logic                  s_we;
  logic [SAW-1:0]        s_waddr, s_raddr;
  logic [7:0]            s_wdata, s_rdata;

  logic [EW-1:0]         pal, p2, nxt_code, nxt_add, cw_pow;
  logic [3:0]            init_w;
  logic [4:0]            msz_inc;
  logic [BB-1:0]         mask;
  logic [EW-1:0]         code13, c13;
  logic                  walk_go, lvl_room, load_out, cfg_wr;

  glzw_dict #(.DEPTH(DICT_ENTRIES)) u_dict (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wprefix(prev_r), .wsuffix(f_r),
    .raddr(d_raddr), .rprefix(d_rprefix), .rsuffix(d_rsuffix)
  );

  glzw_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == glzw_pkg::REG_MINSIZE) ? {28'd0, msz_r} : {29'd0, pb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r  <= 3'd7;
      msz_r <= 4'd8;
    end else if (cfg_wr) begin
      if (paddr[2] == glzw_pkg::REG_PALETTE) begin
        pb_r <= pwdata[2:0];
      end else begin
        msz_r <= pwdata[3:0];
      end
    end
  end

  // Code classification values.
  assign pal      = EW'(1) << ({1'b0, pb_r} + 4'd1);
  assign p2       = pal + EW'(2);
  assign nxt_code = p2 + ec_r;
  assign nxt_add  = nxt_code + EW'(1);
  assign cw_pow   = EW'(1) << cw_r;
  assign msz_inc  = {1'b0, msz_r} + 5'd1;
  assign init_w   = (msz_inc > 5'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS) : msz_inc[3:0];
  assign mask     = (BB'(1) << cw_r) - BB'(1);
  assign code13   = {1'b0, buf_r[CDW-1:0] & mask[CDW-1:0]};
  assign c13      = {1'b0, c_r};
  assign walk_go  = (c13 >= p2) && (c13 < EW'(DICT_ENTRIES)) &&
                    (guard_r < GW'(DICT_ENTRIES));
  assign lvl_room = lvl_r < LW'(STACK_DEPTH);
  assign load_out = (state_r == glzw_pkg::S_DONE) && (!ov_r || out_ch.ready);

  assign in_ch.ready = (state_r == glzw_pkg::S_IDLE);
  assign d_raddr     = c_r[DAW-1:0];
  assign d_waddr     = nxt_code[DAW-1:0];
  assign s_raddr     = SAW'(lvl_r - LW'(1));

  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    cw_nxt    = cw_r;
    ec_nxt    = ec_r;
    prev_nxt  = prev_r;
    aclr_nxt  = aclr_r;
    stop_nxt  = stop_r;
    lvl_nxt   = lvl_r;
    c_nxt     = c_r;
    cur_nxt   = cur_r;
    kwk_nxt   = kwk_r;
    base_nxt  = base_r;
    rsv_nxt   = rsv_r;
    f_nxt     = f_r;
    guard_nxt = guard_r;
    stat_nxt  = stat_r;
    pix_nxt   = pix_r;
    pv_nxt    = pv_r;
    d_we      = 1'b0;
    s_we      = 1'b0;
    s_waddr   = lvl_r[SAW-1:0];
    s_wdata   = 8'd0;
    unique case (state_r)
      glzw_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          stat_nxt  = glzw_pkg::ST_OK;
          pix_nxt   = 8'd0;
          pv_nxt    = 1'b0;
          state_nxt = glzw_pkg::S_DONE;
          unique case (glzw_pkg::action_t'(in_ch.action))
            glzw_pkg::ACT_PUSH: begin
              if (!stop_r) begin
                if ({1'b0, cnt_r} + 6'd8 > 6'(BB)) begin
                  stat_nxt = glzw_pkg::ST_FULL;
                end else begin
                  buf_nxt = buf_r | (BB'(in_ch.data_byte) << cnt_r);
                  cnt_nxt = cnt_r + 5'd8;
                end
              end
            end
            glzw_pkg::ACT_PULL: state_nxt = glzw_pkg::S_DECODE;
            glzw_pkg::ACT_START: begin
              ec_nxt   = '0;
              buf_nxt  = '0;
              cnt_nxt  = '0;
              cw_nxt   = init_w;
              prev_nxt = '0;
              aclr_nxt = 1'b1;
              stop_nxt = 1'b0;
              lvl_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      glzw_pkg::S_DECODE: begin
        if (lvl_r == '0 && !stop_r && cnt_r >= {1'b0, cw_r}) begin
          buf_nxt = buf_r >> cw_r;
          cnt_nxt = cnt_r - {1'b0, cw_r};
          if (code13 == pal) begin
            ec_nxt   = '0;
            cw_nxt   = init_w;
            prev_nxt = '0;
            aclr_nxt = 1'b1;
          end else if (code13 == pal + EW'(1)) begin
            stop_nxt = 1'b1;
            buf_nxt  = '0;
            cnt_nxt  = '0;
          end else if (aclr_r) begin
            if (code13 >= pal) begin
              stat_nxt = glzw_pkg::ST_BADCODE;
            end else begin
              s_we     = lvl_room;
              s_wdata  = code13[7:0];
              lvl_nxt  = lvl_room ? lvl_r + LW'(1) : lvl_r;
              prev_nxt = code13[CDW-1:0];
              aclr_nxt = 1'b0;
              if (cw_r < 4'(MAX_CODE_BITS) && nxt_code == cw_pow) begin
                cw_nxt = cw_r + 4'd1;
              end
            end
          end else begin
            cur_nxt   = code13[CDW-1:0];
            guard_nxt = '0;
            // KwKwK: reserve the bottom slot for the first pixel, filled after the walk.
            if (code13 >= nxt_code) begin
              kwk_nxt  = 1'b1;
              c_nxt    = prev_r;
              base_nxt = lvl_r[SAW-1:0];
              rsv_nxt  = lvl_room;
              lvl_nxt  = lvl_room ? lvl_r + LW'(1) : lvl_r;
            end else begin
              kwk_nxt = 1'b0;
              c_nxt   = code13[CDW-1:0];
              rsv_nxt = 1'b0;
            end
            state_nxt = glzw_pkg::S_WALK_RD;
          end
        end else if (lvl_r != '0) begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = glzw_pkg::S_POP_DAT;
        end else begin
          state_nxt = glzw_pkg::S_DONE;
        end
      end
      glzw_pkg::S_WALK_RD: begin
        if (walk_go) begin
          state_nxt = glzw_pkg::S_WALK_DAT;
        end else begin
          s_we      = lvl_room;
          s_wdata   = c_r[7:0];
          lvl_nxt   = lvl_room ? lvl_r + LW'(1) : lvl_r;
          f_nxt     = c_r[7:0];
          state_nxt = glzw_pkg::S_FIX;
        end
      end
      glzw_pkg::S_WALK_DAT: begin
        s_we      = lvl_room;
        s_wdata   = d_rsuffix;
        lvl_nxt   = lvl_room ? lvl_r + LW'(1) : lvl_r;
        c_nxt     = d_rprefix;
        guard_nxt = guard_r + GW'(1);
        state_nxt = glzw_pkg::S_WALK_RD;
      end
      glzw_pkg::S_FIX: begin
        s_we    = kwk_r && rsv_r;
        s_waddr = base_r;
        s_wdata = f_r;
        if (nxt_code < EW'(DICT_ENTRIES)) begin
          d_we   = 1'b1;
          ec_nxt = ec_r + EW'(1);
          if (cw_r < 4'(MAX_CODE_BITS) && nxt_add == cw_pow) begin
            cw_nxt = cw_r + 4'd1;
          end
        end else if (cw_r < 4'(MAX_CODE_BITS) && nxt_code == cw_pow) begin
          cw_nxt = cw_r + 4'd1;
        end
        prev_nxt  = cur_r;
        state_nxt = glzw_pkg::S_DECODE;
      end
      glzw_pkg::S_POP_DAT: begin
        pix_nxt   = s_rdata;
        pv_nxt    = 1'b1;
        state_nxt = glzw_pkg::S_DONE;
      end
      glzw_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = glzw_pkg::S_IDLE;
        end
      end
      default: state_nxt = glzw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glzw_pkg::S_IDLE;
      buf_r   <= '0;
      cnt_r   <= '0;
      cw_r    <= 4'd9;
      ec_r    <= '0;
      prev_r  <= '0;
      aclr_r  <= 1'b1;
      stop_r  <= 1'b0;
      lvl_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      cw_r    <= cw_nxt;
      ec_r    <= ec_nxt;
      prev_r  <= prev_nxt;
      aclr_r  <= aclr_nxt;
      stop_r  <= stop_nxt;
      lvl_r   <= lvl_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    cur_r   <= cur_nxt;
    kwk_r   <= kwk_nxt;
    base_r  <= base_nxt;
    rsv_r   <= rsv_nxt;
    f_r     <= f_nxt;
    guard_r <= guard_nxt;
    stat_r  <= stat_nxt;
    pix_r   <= pix_nxt;
    pv_r    <= pv_nxt;
    if (state_r == glzw_pkg::S_IDLE && in_ch.valid) begin
      act_r <= in_ch.action;
    end
    if (load_out) begin
      o_pix_r  <= (act_r == glzw_pkg::ACT_PULL) ? pix_r : 8'd0;
      o_pv_r   <= (act_r == glzw_pkg::ACT_PULL) && pv_r;
      o_need_r <= (cnt_r < {1'b0, cw_r}) && (lvl_r == '0);
      o_end_r  <= stop_r;
      o_stat_r <= stat_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pixel       = o_pix_r;
  assign out_ch.pixel_valid = o_pv_r;
  assign out_ch.need_byte   = o_need_r;
  assign out_ch.image_end   = o_end_r;
  assign out_ch.status      = o_stat_r;
endmodule

[rtl/core/glzw_dict.sv]
`timescale 1ns / 1ps
// Dictionary memory: prefix code and suffix pixel per entry.
// One write port, one registered read port. Uses glzw_pkg.
module glzw_dict #(
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [glzw_pkg::CODE_W-1:0] wprefix,
  input  logic [7:0]                   wsuffix,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [glzw_pkg::CODE_W-1:0] rprefix,
  output logic [7:0]                   rsuffix
);
  logic [glzw_pkg::CODE_W-1:0] pre_mem [DEPTH];
  logic [7:0]                  suf_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pre_mem[waddr] <= wprefix;
      suf_mem[waddr] <= wsuffix;
    end
    rprefix <= pre_mem[raddr];
    rsuffix <= suf_mem[raddr];
  end
endmodule

[rtl/core/glzw_stack.sv]
`timescale 1ns / 1ps
// Pixel stack memory holding one decoded string, popped last in first out.
// One write port, one registered read port. No package dependency.
module glzw_stack #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of gif_lzw_decoder_unit: directed beats, then random LZW images.
// Typed rows are checked against their own entry, other beats against a decoder model.
// Depends on glzw_pkg, glzw_chan_if and the RTL of the decoder.
module testbench;

  typedef struct packed {
    logic [7:0]        pixel;
    logic              pixel_valid;
    logic              need_byte;
    logic              image_end;
    glzw_pkg::status_t status;
  } result_t;

  typedef struct packed {
    glzw_pkg::action_t act;
    logic [7:0]        dbyte;
    logic              typed;
    result_t           res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  glzw_in_if  in_bus ();
  glzw_out_if out_bus ();

  gif_lzw_decoder_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Decoder model state.
  bit [2:0]  cfg_pal_bits;
  bit [3:0]  cfg_min_size;
  bit [11:0] dict_pfx [4096];
  bit [7:0]  dict_sfx [4096];
  bit [7:0]  px_stack [4096];
  bit [12:0] m_entries;
  bit [19:0] m_buf;
  bit [4:0]  m_nbits;
  bit [3:0]  m_width;
  bit [11:0] m_prev;
  bit        m_after_clear;
  bit        m_stop;
  bit [12:0] m_level;

  result_t due_beats [$];
  int      errors;
  int      rand_sent;
  int      send_idle;
  int      rcv_idle;
  byte unsigned img_bytes [$];

  dir_row_t dir_rows [24] = '{
    '{glzw_pkg::ACT_NOP,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h01, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'hAA, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, glzw_pkg::ST_FULL}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_BADCODE}},
    '{glzw_pkg::ACT_START, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h01, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h01, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_START, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0, glzw_pkg::ST_OK}},
    '{glzw_pkg::ACT_PUSH,  8'h5A, 1'b0, '0},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b0, '0},
    '{glzw_pkg::ACT_PUSH,  8'hA5, 1'b0, '0},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b0, '0},
    '{glzw_pkg::ACT_PULL,  8'h00, 1'b0, '0},
    '{glzw_pkg::ACT_NOP,   8'h3C, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL gif_lzw_decoder_unit");
    $finish;
  end

  function automatic int pal_size();
    return 1 << (cfg_pal_bits + 1);
  endfunction

  function automatic bit [3:0] start_width();
    return (cfg_min_size + 1 > 12) ? 4'd12 : 4'(cfg_min_size + 1);
  endfunction

  function automatic void stack_pixel(bit [7:0] v);
    if (m_level < 4096) begin
      px_stack[m_level] = v;
      m_level++;
    end
  endfunction

  // Follows a string back to its root color; pushes the pixels when asked.
  function automatic bit [7:0] walk_chain(int c, bit emit);
    int p2, guard;
    p2 = pal_size() + 2;
    guard = 0;
    while (c >= p2 && c < 4096 && guard < 4096) begin
      if (emit) stack_pixel(dict_sfx[c]);
      c = dict_pfx[c];
      guard++;
    end
    if (emit) stack_pixel(c[7:0]);
    return c[7:0];
  endfunction

  function automatic void add_entry(bit [11:0] pre, bit [7:0] suf);
    int nxt;
    nxt = pal_size() + 2 + m_entries;
    if (nxt < 4096) begin
      dict_pfx[nxt] = pre;
      dict_sfx[nxt] = suf;
      m_entries++;
    end
  endfunction

  function automatic void begin_image();
    m_entries = 0;
    m_buf = 0;
    m_nbits = 0;
    m_width = start_width();
    m_prev = 0;
    m_after_clear = 1'b1;
    m_stop = 1'b0;
    m_level = 0;
  endfunction

  function automatic glzw_pkg::status_t decode_code(int code);
    int p, nxt;
    bit [7:0] f;
    p = pal_size();
    if (code == p) begin
      m_entries = 0;
      m_width = start_width();
      m_prev = 0;
      m_after_clear = 1'b1;
      return glzw_pkg::ST_OK;
    end
    if (code == p + 1) begin
      m_stop = 1'b1;
      m_buf = 0;
      m_nbits = 0;
      return glzw_pkg::ST_OK;
    end
    nxt = p + 2 + m_entries;
    if (m_after_clear) begin
      if (code >= p) return glzw_pkg::ST_BADCODE;
      stack_pixel(code[7:0]);
      m_prev = code[11:0];
      m_after_clear = 1'b0;
    end else if (code < nxt) begin
      f = walk_chain(code, 1'b0);
      add_entry(m_prev, f);
      void'(walk_chain(code, 1'b1));
      m_prev = code[11:0];
    end else begin
      // Code not yet in the table: previous string plus its own first pixel.
      f = walk_chain(m_prev, 1'b0);
      add_entry(m_prev, f);
      stack_pixel(f);
      void'(walk_chain(m_prev, 1'b1));
      m_prev = code[11:0];
    end
    nxt = p + 2 + m_entries;
    if (m_width < 12 && nxt == (1 << m_width)) m_width++;
    return glzw_pkg::ST_OK;
  endfunction

  function automatic result_t decode_item(glzw_pkg::action_t a, bit [7:0] b);
    result_t r;
    int code;
    glzw_pkg::status_t s;
    r = '0;
    r.status = glzw_pkg::ST_OK;
    case (a)
      glzw_pkg::ACT_PUSH: begin
        if (!m_stop) begin
          if (m_nbits + 8 > 20) r.status = glzw_pkg::ST_FULL;
          else begin
            m_buf = m_buf | (20'(b) << m_nbits);
            m_nbits = m_nbits + 8;
          end
        end
      end
      glzw_pkg::ACT_PULL: begin
        while (m_level == 0 && !m_stop && m_nbits >= m_width) begin
          code = m_buf & ((1 << m_width) - 1);
          m_buf = m_buf >> m_width;
          m_nbits = m_nbits - m_width;
          s = decode_code(code);
          if (s != glzw_pkg::ST_OK) r.status = s;
        end
        if (m_level > 0) begin
          m_level--;
          r.pixel = px_stack[m_level];
          r.pixel_valid = 1'b1;
        end
      end
      glzw_pkg::ACT_START: begin_image();
      default: ;
    endcase
    r.need_byte = (m_nbits < m_width && m_level == 0);
    r.image_end = m_stop;
    return r;
  endfunction

  task automatic send_item(glzw_pkg::action_t a, bit [7:0] b, bit typed,
                           result_t typed_res);
    result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.action = a;
    in_bus.data_byte = b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    r = decode_item(a, b);
    due_beats.push_back(typed ? typed_res : r);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic random_item(glzw_pkg::action_t a, bit [7:0] b);
    rand_sent++;
    if (rand_sent < 583) begin
      send_idle = 37;
      rcv_idle = 49;
    end else if (rand_sent < 1166) begin
      send_idle = 49;
      rcv_idle = 37;
    end else begin
      send_idle = 0;
      rcv_idle = 0;
    end
    send_item(a, b, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (due_beats.size() != 0) @(posedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic cfg_write(logic [0:0] idx, bit [31:0] d);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == glzw_pkg::REG_PALETTE) cfg_pal_bits = d[2:0];
    else cfg_min_size = d[3:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Builds an LZW code stream that an encoder could have produced, packed LSB first.
  task automatic build_image(int ncodes, bit colors_only);
    int p, w, nxt, maxc, code, hi;
    bit first;
    bit [31:0] acc;
    int nacc;
    img_bytes.delete();
    p = pal_size();
    w = start_width();
    nxt = p + 2;
    first = 1'b1;
    acc = 0;
    nacc = 0;
    for (int k = 0; k <= ncodes; k++) begin
      maxc = (1 << w) - 1;
      if (k == ncodes) begin
        if (p + 1 > maxc || $urandom_range(9) == 0) break;
        code = p + 1;
      end else if ((k == 0 && $urandom_range(1) == 1 && p <= maxc) ||
                   (!first && !colors_only && p <= maxc && $urandom_range(99) < 3)) begin
        code = p;
      end else if (first || colors_only || p + 2 > maxc || $urandom_range(1) == 1) begin
        hi = (p - 1 < maxc) ? p - 1 : maxc;
        code = $urandom_range(hi);
      end else begin
        hi = (nxt < maxc) ? nxt : maxc;
        code = $urandom_range(hi, p + 2);
      end
      acc = acc | (code << nacc);
      nacc += w;
      while (nacc >= 8) begin
        img_bytes.push_back(acc[7:0]);
        acc = acc >> 8;
        nacc -= 8;
      end
      if (code == p) begin
        w = start_width();
        nxt = p + 2;
        first = 1'b1;
      end else if (code != p + 1) begin
        if (!first && nxt < 4096) nxt++;
        first = 1'b0;
        if (w < 12 && nxt == (1 << w)) w++;
      end
    end
    if (nacc > 0) img_bytes.push_back(acc[7:0]);
  endtask

  task automatic feed_image();
    int idx;
    glzw_pkg::action_t act;
    idx = 0;
    forever begin
      if ($urandom_range(99) < 4) begin
        act = glzw_pkg::action_t'($urandom_range(3));
        // Extra beats must leave the code stream intact: a start or an accepted
        // byte would not, a refused or discarded byte does.
        if (act == glzw_pkg::ACT_START ||
            (act == glzw_pkg::ACT_PUSH && !m_stop && m_nbits + 8 <= 20)) begin
          act = glzw_pkg::ACT_NOP;
        end
        random_item(act, 8'($urandom_range(255)));
      end else if (m_level > 0 || (m_nbits >= m_width && !m_stop)) begin
        random_item(glzw_pkg::ACT_PULL, 8'($urandom_range(255)));
      end else if (idx < img_bytes.size()) begin
        random_item(glzw_pkg::ACT_PUSH, img_bytes[idx]);
        idx++;
      end else begin
        break;
      end
    end
    random_item(glzw_pkg::ACT_PULL, 8'h00);
    random_item(glzw_pkg::ACT_START, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(bit [2:0] pb, bit [3:0] ms, int nimg);
    wait_drained();
    cfg_write(glzw_pkg::REG_PALETTE, 32'(pb));
    cfg_write(glzw_pkg::REG_MINSIZE, 32'(ms));
    random_item(glzw_pkg::ACT_START, 8'h00);
    for (int i = 0; i < nimg && rand_sent < 1750; i++) begin
      if ($urandom_range(9) == 0) build_image($urandom_range(150, 80), 1'b0);
      else build_image($urandom_range(60, 5), 1'b0);
      feed_image();
    end
  endtask

  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_beats.size() == 0) begin
        $display("%0t: result beat with none expected, actual pixel=%h valid=%b",
                 $time, out_bus.pixel, out_bus.pixel_valid);
        errors++;
      end else begin
        want = due_beats.pop_front();
        if (out_bus.pixel !== want.pixel || out_bus.pixel_valid !== want.pixel_valid ||
            out_bus.need_byte !== want.need_byte || out_bus.image_end !== want.image_end ||
            out_bus.status !== want.status) begin
          $display("%0t: mismatch expected pix=%h pv=%b nb=%b end=%b st=%0d", $time,
                   want.pixel, want.pixel_valid, want.need_byte, want.image_end,
                   want.status);
          $display("%0t:          actual   pix=%h pv=%b nb=%b end=%b st=%0d", $time,
                   out_bus.pixel, out_bus.pixel_valid, out_bus.need_byte,
                   out_bus.image_end, out_bus.status);
          errors++;
        end
      end
    end
  end

  initial begin
    bit [2:0] settings_pb [6];
    bit [3:0] settings_ms [6];
    int ph;
    settings_pb = '{3'd7, 3'd0, 3'd7, 3'd0, 3'd3, 3'd1};
    settings_ms = '{4'd8, 4'd2, 4'd2, 4'd8, 4'd4, 4'd3};
    errors = 0;
    rand_sent = 0;
    send_idle = 0;
    rcv_idle = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = glzw_pkg::ACT_NOP;
    in_bus.data_byte = '0;
    out_bus.ready = 1'b0;
    cfg_pal_bits = 3'd7;
    cfg_min_size = 4'd8;
    begin_image();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].act, dir_rows[i].dbyte, dir_rows[i].typed,
                                    dir_rows[i].res);

    ph = 0;
    while (rand_sent < 1750) begin
      if (ph < 6) run_phase(settings_pb[ph], settings_ms[ph], $urandom_range(4, 2));
      else run_phase(3'($urandom_range(7)), 4'($urandom_range(8, 2)), $urandom_range(4, 2));
      ph++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gif_lzw_decoder_unit");
    end else begin
      $display("FAIL gif_lzw_decoder_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/glzw_pkg.sv
rtl/core/glzw_chan_if.sv
rtl/core/glzw_dict.sv
rtl/core/glzw_stack.sv
rtl/core/gif_lzw_decoder_unit.sv
tb/sv/testbench.sv
